// ===== rtl/nps_pkg.sv =====
// nps_pkg: shared sizes, opcode and status codes, FSM state type and the
// controller/datapath command and status bundles for nearest_peak_adjacent_scan.
// No dependencies.
package nps_pkg;

    localparam int MAX_SCANS = 64;
    localparam int MAX_PEAKS = 256;
    localparam int MZ_W      = 32;

    localparam int SCAN_W    = $clog2(MAX_SCANS);
    localparam int PEAK_W    = $clog2(MAX_PEAKS);
    localparam int CNT_W     = PEAK_W + 1;
    localparam int ADDR_W    = SCAN_W + PEAK_W;
    localparam int CFG_W     = 7;
    localparam int FUNC_W    = 2;
    localparam int STATUS_W  = 2;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_WR_PEAK   = 2'd0,
        FUNC_SET_LEN   = 2'd1,
        FUNC_STEP_NEXT = 2'd2,
        FUNC_STEP_PREV = 2'd3
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK      = 2'd0,
        STAT_NO_SUCC = 2'd1,
        STAT_RANGE   = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_CHECK,
        S_INIT,
        S_PROBE,
        S_CMP,
        S_NB_HI,
        S_NB_LO,
        S_PICK,
        S_DONE
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load_in;     // capture the input transaction
        logic do_exec;     // perform writes; current-scan reads are in flight
        logic check;       // range/edge check, latch current m/z, read adjacent length
        logic init;        // start the lower-bound search
        logic probe;       // read peak at lo + n/2
        logic cmp;         // fold the probe result into lo/n
        logic end_search;  // trivial result: past end or first peak
        logic rd_hi;       // read peak at lo
        logic rd_nb;       // keep distance to peak lo, read peak lo-1
        logic pick;        // choose the closer of the two
        logic out_load;    // move the result into the output register
    } nps_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_step;
        logic step_bad;
        logic step_edge;
        logic n_zero;
        logic lo_trivial;
        logic out_free;
    } nps_stat_t;

endpackage

// ===== rtl/nearest_peak_adjacent_scan.sv =====
// nearest_peak_adjacent_scan: top level, controller plus datapath.
// Depends on nps_pkg, nps_ctrl and nps_dpath.
//
// Peak map with nearest-peak lookup in the neighboring scan. func 0 writes one
// 16.16 m/z value at (scan, peak), func 1 sets a scan's peak count (saturated
// to 256), func 2/3 step to the next/previous scan: the current peak's m/z is
// read, the adjacent scan is lower-bound searched, and the closer of the bound
// and its left neighbor is returned (tie goes left). Status 2 flags indices out
// of range (checked first), status 1 a step off the edge of the map; in those
// cases the transaction's scan and peak come back unchanged. Every input
// transaction yields exactly one output transaction. Throughput: one
// transaction at a time, set by the single-port peak store whose registered
// read feeds the next search address. A write passes through execute and
// done; a step adds the range/edge check, and a full step goes on to init,
// k probe/compare rounds, where k is the number of search probes (at most
// ceil(log2(len+1)), so up to 9 for 256 peaks, none for an empty scan), the
// neighbor reads and the pick, skipping the last two when the result falls
// past the end or on the first peak. The output register lets a finished
// result wait for m_ready without stalling the search of the next transaction
// past its final cycle. scan_total (cfg_wr_*) resets to 64, values above 64
// act as 64; write it only while idle. Reading a peak slot never written gives
// an undefined result; scan lengths reset to 0.
module nearest_peak_adjacent_scan (
    input  logic                         aclk,
    input  logic                         aresetn,
    // configuration
    input  logic                         cfg_wr_en,
    input  logic [nps_pkg::CFG_W-1:0]    cfg_wr_data,
    // input channel
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [nps_pkg::FUNC_W-1:0]   s_func,
    input  logic [nps_pkg::SCAN_W-1:0]   s_scan_index,
    input  logic [nps_pkg::PEAK_W-1:0]   s_peak_index,
    input  logic [nps_pkg::MZ_W-1:0]     s_mz_value,
    input  logic [nps_pkg::CNT_W-1:0]    s_peak_count,
    // result channel
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [nps_pkg::SCAN_W-1:0]   m_new_scan,
    output logic [nps_pkg::PEAK_W-1:0]   m_new_peak,
    output logic [nps_pkg::STATUS_W-1:0] m_status
);

    // command and status bundles between sequencer and datapath
    nps_pkg::nps_cmd_t  cmd;
    nps_pkg::nps_stat_t stat;

    nps_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    nps_dpath u_dpath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_func       (s_func),
        .s_scan_index (s_scan_index),
        .s_peak_index (s_peak_index),
        .s_mz_value   (s_mz_value),
        .s_peak_count (s_peak_count),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_new_scan   (m_new_scan),
        .m_new_peak   (m_new_peak),
        .m_status     (m_status),
        .cmd          (cmd),
        .stat         (stat)
    );

endmodule

// ===== rtl/nps_ctrl.sv =====
// nps_ctrl: sequencing state machine for nearest_peak_adjacent_scan.
// Depends on nps_pkg (state_t, nps_cmd_t, nps_stat_t).
module nps_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  nps_pkg::nps_stat_t stat,
    output nps_pkg::nps_cmd_t  cmd
);

    nps_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= nps_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            nps_pkg::S_IDLE: begin
                if (s_valid) state_next = nps_pkg::S_EXEC;
            end
            nps_pkg::S_EXEC: begin
                state_next = stat.is_step ? nps_pkg::S_CHECK : nps_pkg::S_DONE;
            end
            nps_pkg::S_CHECK: begin
                if (stat.step_bad || stat.step_edge) state_next = nps_pkg::S_DONE;
                else                                 state_next = nps_pkg::S_INIT;
            end
            nps_pkg::S_INIT: begin
                state_next = nps_pkg::S_PROBE;
            end
            nps_pkg::S_PROBE: begin
                state_next = stat.n_zero ? nps_pkg::S_NB_HI : nps_pkg::S_CMP;
            end
            nps_pkg::S_CMP: begin
                state_next = nps_pkg::S_PROBE;
            end
            nps_pkg::S_NB_HI: begin
                state_next = stat.lo_trivial ? nps_pkg::S_DONE : nps_pkg::S_NB_LO;
            end
            nps_pkg::S_NB_LO: begin
                state_next = nps_pkg::S_PICK;
            end
            nps_pkg::S_PICK: begin
                state_next = nps_pkg::S_DONE;
            end
            nps_pkg::S_DONE: begin
                if (stat.out_free) state_next = nps_pkg::S_IDLE;
            end
            default: begin
                state_next = nps_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            nps_pkg::S_IDLE: begin
                s_ready     = 1'b1;
                cmd.load_in = s_valid;
            end
            nps_pkg::S_EXEC: begin
                cmd.do_exec = 1'b1;
            end
            nps_pkg::S_CHECK: begin
                cmd.check = 1'b1;
            end
            nps_pkg::S_INIT: begin
                cmd.init = 1'b1;
            end
            nps_pkg::S_PROBE: begin
                cmd.probe = !stat.n_zero;
            end
            nps_pkg::S_CMP: begin
                cmd.cmp = 1'b1;
            end
            nps_pkg::S_NB_HI: begin
                cmd.end_search = stat.lo_trivial;
                cmd.rd_hi      = !stat.lo_trivial;
            end
            nps_pkg::S_NB_LO: begin
                cmd.rd_nb = 1'b1;
            end
            nps_pkg::S_PICK: begin
                cmd.pick = 1'b1;
            end
            nps_pkg::S_DONE: begin
                cmd.out_load = stat.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== rtl/nps_dpath.sv =====
// nps_dpath: peak store, scan length table, search registers and output register.
// Depends on nps_pkg; driven by nps_ctrl through nps_cmd_t / nps_stat_t.
module nps_dpath (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [nps_pkg::CFG_W-1:0]       cfg_wr_data,
    input  logic [nps_pkg::FUNC_W-1:0]      s_func,
    input  logic [nps_pkg::SCAN_W-1:0]      s_scan_index,
    input  logic [nps_pkg::PEAK_W-1:0]      s_peak_index,
    input  logic [nps_pkg::MZ_W-1:0]        s_mz_value,
    input  logic [nps_pkg::CNT_W-1:0]       s_peak_count,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [nps_pkg::SCAN_W-1:0]      m_new_scan,
    output logic [nps_pkg::PEAK_W-1:0]      m_new_peak,
    output logic [nps_pkg::STATUS_W-1:0]    m_status,
    input  nps_pkg::nps_cmd_t               cmd,
    output nps_pkg::nps_stat_t              stat
);

    // storage
    logic [nps_pkg::MZ_W-1:0]   peak_mem [nps_pkg::MAX_SCANS*nps_pkg::MAX_PEAKS];
    logic [nps_pkg::CNT_W-1:0]  len_mem  [nps_pkg::MAX_SCANS];
    logic [nps_pkg::MAX_SCANS-1:0] len_vld_reg;

    logic [nps_pkg::CFG_W-1:0]  scan_total_reg;

    // captured transaction
    nps_pkg::func_t             func_reg;
    logic [nps_pkg::SCAN_W-1:0] scan_reg;
    logic [nps_pkg::PEAK_W-1:0] peak_reg;
    logic [nps_pkg::MZ_W-1:0]   mz_reg;
    logic [nps_pkg::CNT_W-1:0]  count_reg;

    // search
    logic [nps_pkg::MZ_W-1:0]   cur_reg;
    logic [nps_pkg::SCAN_W-1:0] adj_reg;
    logic [nps_pkg::CNT_W-1:0]  lo_reg;
    logic [nps_pkg::CNT_W-1:0]  n_reg;
    logic [nps_pkg::CNT_W-1:0]  len_adj_reg;
    logic [nps_pkg::MZ_W-1:0]   diff_hi_reg;

    // result and output
    logic [nps_pkg::SCAN_W-1:0] res_scan_reg;
    logic [nps_pkg::PEAK_W-1:0] res_peak_reg;
    nps_pkg::status_t           res_status_reg;
    logic                       m_valid_reg;
    logic [nps_pkg::SCAN_W-1:0] m_scan_reg;
    logic [nps_pkg::PEAK_W-1:0] m_peak_reg;
    logic [nps_pkg::STATUS_W-1:0] m_status_reg;

    // memory ports
    logic [nps_pkg::ADDR_W-1:0] peak_addr;
    logic                       peak_we;
    logic [nps_pkg::MZ_W-1:0]   peak_rd_reg;
    logic [nps_pkg::SCAN_W-1:0] len_addr;
    logic                       len_we;
    logic [nps_pkg::CNT_W-1:0]  len_rd_reg;
    logic                       len_vld_rd_reg;

    // combinational helpers
    logic [nps_pkg::CFG_W-1:0]  total_eff;
    logic [nps_pkg::CNT_W-1:0]  len_eff;
    logic [nps_pkg::CNT_W-1:0]  count_sat;
    logic                       wr_bad;
    logic [nps_pkg::SCAN_W-1:0] adj_next;
    logic [nps_pkg::CNT_W-1:0]  half;
    logic [nps_pkg::CNT_W-1:0]  mid;
    logic [nps_pkg::CNT_W-1:0]  lo_m1;
    logic [nps_pkg::CNT_W-1:0]  trivial_peak;
    logic [nps_pkg::MZ_W-1:0]   diff_hi;
    logic [nps_pkg::MZ_W-1:0]   diff_lo;
    logic                       is_step;

    assign total_eff = (scan_total_reg > nps_pkg::CFG_W'(nps_pkg::MAX_SCANS))
                     ? nps_pkg::CFG_W'(nps_pkg::MAX_SCANS) : scan_total_reg;
    assign len_eff   = len_vld_rd_reg ? len_rd_reg : '0;
    assign count_sat = (count_reg > nps_pkg::CNT_W'(nps_pkg::MAX_PEAKS))
                     ? nps_pkg::CNT_W'(nps_pkg::MAX_PEAKS) : count_reg;
    assign wr_bad    = (int'(scan_reg) >= nps_pkg::MAX_SCANS)
                    || ((func_reg == nps_pkg::FUNC_WR_PEAK)
                        && (int'(peak_reg) >= nps_pkg::MAX_PEAKS));
    assign is_step   = (func_reg == nps_pkg::FUNC_STEP_NEXT)
                    || (func_reg == nps_pkg::FUNC_STEP_PREV);
    assign adj_next  = (func_reg == nps_pkg::FUNC_STEP_NEXT)
                     ? scan_reg + nps_pkg::SCAN_W'(1) : scan_reg - nps_pkg::SCAN_W'(1);

    assign half  = n_reg >> 1;
    assign mid   = lo_reg + half;
    assign lo_m1 = lo_reg - nps_pkg::CNT_W'(1);
    assign trivial_peak = (lo_reg >= len_adj_reg)
                        ? ((len_adj_reg != '0) ? len_adj_reg - nps_pkg::CNT_W'(1) : '0)
                        : '0;

    assign diff_hi = (peak_rd_reg >= cur_reg) ? peak_rd_reg - cur_reg : cur_reg - peak_rd_reg;
    assign diff_lo = (cur_reg >= peak_rd_reg) ? cur_reg - peak_rd_reg : peak_rd_reg - cur_reg;

    // status to controller
    always_comb begin
        stat.is_step    = is_step;
        stat.step_bad   = (nps_pkg::CFG_W'(scan_reg) >= total_eff)
                       || (nps_pkg::CNT_W'(peak_reg) >= len_eff);
        stat.step_edge  = (func_reg == nps_pkg::FUNC_STEP_NEXT)
                        ? (nps_pkg::CFG_W'(scan_reg) + nps_pkg::CFG_W'(1) == total_eff)
                        : (scan_reg == '0);
        stat.n_zero     = (n_reg == '0);
        stat.lo_trivial = (lo_reg >= len_adj_reg) || (lo_reg == '0);
        stat.out_free   = !m_valid_reg || m_ready;
    end

    // peak store port
    always_comb begin
        peak_addr = {scan_reg, peak_reg};
        if (cmd.probe) begin
            peak_addr = {adj_reg, mid[nps_pkg::PEAK_W-1:0]};
        end else if (cmd.rd_hi) begin
            peak_addr = {adj_reg, lo_reg[nps_pkg::PEAK_W-1:0]};
        end else if (cmd.rd_nb) begin
            peak_addr = {adj_reg, lo_m1[nps_pkg::PEAK_W-1:0]};
        end
    end
    assign peak_we = cmd.do_exec && (func_reg == nps_pkg::FUNC_WR_PEAK) && !wr_bad;

    always_ff @(posedge aclk) begin
        if (peak_we) begin
            peak_mem[peak_addr] <= mz_reg;
        end
        peak_rd_reg <= peak_mem[peak_addr];
    end

    // scan length table; valid bits stand in for the all-zero reset
    assign len_addr = cmd.check ? adj_next : scan_reg;
    assign len_we   = cmd.do_exec && (func_reg == nps_pkg::FUNC_SET_LEN) && !wr_bad;

    always_ff @(posedge aclk) begin
        if (len_we) begin
            len_mem[len_addr] <= count_sat;
        end
        len_rd_reg <= len_mem[len_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_vld_reg    <= '0;
            len_vld_rd_reg <= 1'b0;
        end else begin
            if (len_we) begin
                len_vld_reg[len_addr] <= 1'b1;
            end
            len_vld_rd_reg <= len_vld_reg[len_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_total_reg <= nps_pkg::CFG_W'(nps_pkg::MAX_SCANS);
        end else if (cfg_wr_en) begin
            scan_total_reg <= cfg_wr_data;
        end
    end

    // transaction capture, search and result
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            func_reg       <= nps_pkg::func_t'(s_func);
            scan_reg       <= s_scan_index;
            peak_reg       <= s_peak_index;
            mz_reg         <= s_mz_value;
            count_reg      <= s_peak_count;
            res_scan_reg   <= s_scan_index;
            res_peak_reg   <= s_peak_index;
            res_status_reg <= nps_pkg::STAT_OK;
        end
        if (cmd.do_exec && !is_step && wr_bad) begin
            res_status_reg <= nps_pkg::STAT_RANGE;
        end
        if (cmd.check) begin
            cur_reg <= peak_rd_reg;
            adj_reg <= adj_next;
            if (stat.step_bad) begin
                res_status_reg <= nps_pkg::STAT_RANGE;
            end else if (stat.step_edge) begin
                res_status_reg <= nps_pkg::STAT_NO_SUCC;
            end
        end
        if (cmd.init) begin
            lo_reg      <= '0;
            n_reg       <= len_eff;
            len_adj_reg <= len_eff;
        end
        if (cmd.cmp) begin
            if (peak_rd_reg < cur_reg) begin
                lo_reg <= mid + nps_pkg::CNT_W'(1);
                n_reg  <= n_reg - half - nps_pkg::CNT_W'(1);
            end else begin
                n_reg  <= half;
            end
        end
        if (cmd.end_search) begin
            res_scan_reg <= adj_reg;
            res_peak_reg <= trivial_peak[nps_pkg::PEAK_W-1:0];
        end
        if (cmd.rd_nb) begin
            diff_hi_reg <= diff_hi;
        end
        if (cmd.pick) begin
            res_scan_reg <= adj_reg;
            res_peak_reg <= (diff_hi_reg < diff_lo) ? lo_reg[nps_pkg::PEAK_W-1:0]
                                                    : lo_m1[nps_pkg::PEAK_W-1:0];
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_scan_reg   <= res_scan_reg;
            m_peak_reg   <= res_peak_reg;
            m_status_reg <= res_status_reg;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_new_scan = m_scan_reg;
    assign m_new_peak = m_peak_reg;
    assign m_status   = m_status_reg;

endmodule

// ===== dv/nps_result_check.sv =====
// nps_result_check: watches both channels and the scan_total write port of
// nearest_peak_adjacent_scan, predicts each result and compares field by field.
// Depends on nps_pkg.
`timescale 1ns / 1ps

module nps_result_check (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [nps_pkg::CFG_W-1:0]    cfg_wr_data,
    input  logic                         s_valid,
    input  logic                         s_ready,
    input  logic [nps_pkg::FUNC_W-1:0]   s_func,
    input  logic [nps_pkg::SCAN_W-1:0]   s_scan_index,
    input  logic [nps_pkg::PEAK_W-1:0]   s_peak_index,
    input  logic [nps_pkg::MZ_W-1:0]     s_mz_value,
    input  logic [nps_pkg::CNT_W-1:0]    s_peak_count,
    input  logic                         m_valid,
    input  logic                         m_ready,
    input  logic [nps_pkg::SCAN_W-1:0]   m_new_scan,
    input  logic [nps_pkg::PEAK_W-1:0]   m_new_peak,
    input  logic [nps_pkg::STATUS_W-1:0] m_status,
    output int                           awaited_count,
    output int                           mismatch_count
);

    typedef struct packed {
        logic [nps_pkg::SCAN_W-1:0] scan;
        logic [nps_pkg::PEAK_W-1:0] peak;
        nps_pkg::status_t           status;
    } step_result_t;

    logic [nps_pkg::MZ_W-1:0]  peak_mem [nps_pkg::MAX_SCANS*nps_pkg::MAX_PEAKS];
    logic [nps_pkg::CNT_W-1:0] len_mem [nps_pkg::MAX_SCANS];
    logic [nps_pkg::CFG_W-1:0] cfg_total;
    step_result_t              awaited [$];

    // Lower bound in the adjacent scan, then the closer of the bound and its
    // left neighbor; equal distance goes left.
    function automatic logic [nps_pkg::PEAK_W-1:0] closest_peak(
        input int unsigned adj,
        input logic [nps_pkg::MZ_W-1:0] mz);
        int unsigned              len, lo, n, half;
        logic [nps_pkg::MZ_W-1:0] hi_v, lo_v, d_hi, d_lo;
        len = len_mem[adj];
        lo  = 0;
        n   = len;
        while (n > 0) begin
            half = n / 2;
            if (peak_mem[adj * nps_pkg::MAX_PEAKS + lo + half] < mz) begin
                lo = lo + half + 1;
                n  = n - half - 1;
            end else begin
                n = half;
            end
        end
        if (lo >= len) return (len > 0) ? nps_pkg::PEAK_W'(len - 1) : '0;
        if (lo == 0) return '0;
        hi_v = peak_mem[adj * nps_pkg::MAX_PEAKS + lo];
        lo_v = peak_mem[adj * nps_pkg::MAX_PEAKS + lo - 1];
        d_hi = (hi_v >= mz) ? hi_v - mz : mz - hi_v;
        d_lo = (mz >= lo_v) ? mz - lo_v : lo_v - mz;
        return (d_hi < d_lo) ? nps_pkg::PEAK_W'(lo) : nps_pkg::PEAK_W'(lo - 1);
    endfunction

    // Applies one input transaction to the local map and returns its result.
    function automatic step_result_t resolve_request(
        input nps_pkg::func_t op,
        input logic [nps_pkg::SCAN_W-1:0] sc,
        input logic [nps_pkg::PEAK_W-1:0] pk,
        input logic [nps_pkg::MZ_W-1:0] mz,
        input logic [nps_pkg::CNT_W-1:0] cnt);
        step_result_t r;
        int unsigned  lim, adj;
        r.scan   = sc;
        r.peak   = pk;
        r.status = nps_pkg::STAT_OK;
        lim = (cfg_total > nps_pkg::MAX_SCANS) ? nps_pkg::MAX_SCANS : cfg_total;
        case (op)
            nps_pkg::FUNC_WR_PEAK: peak_mem[sc * nps_pkg::MAX_PEAKS + pk] = mz;
            nps_pkg::FUNC_SET_LEN: len_mem[sc] = (cnt > nps_pkg::MAX_PEAKS)
                                               ? nps_pkg::CNT_W'(nps_pkg::MAX_PEAKS) : cnt;
            default: begin
                if (sc >= lim || pk >= len_mem[sc]) begin
                    r.status = nps_pkg::STAT_RANGE;
                end else if (op == nps_pkg::FUNC_STEP_NEXT ? (sc + 1 == lim)
                                                           : (sc == 0)) begin
                    r.status = nps_pkg::STAT_NO_SUCC;
                end else begin
                    adj    = (op == nps_pkg::FUNC_STEP_NEXT) ? sc + 1 : sc - 1;
                    r.scan = nps_pkg::SCAN_W'(adj);
                    r.peak = closest_peak(adj, peak_mem[sc * nps_pkg::MAX_PEAKS + pk]);
                end
            end
        endcase
        return r;
    endfunction

    always @(posedge aclk) begin : watch
        step_result_t want;
        int           errs;
        errs = 0;
        if (!aresetn) begin
            awaited.delete();
            cfg_total = 7'd64;
            for (int i = 0; i < nps_pkg::MAX_SCANS; i++) len_mem[i] = '0;
        end else begin
            if (cfg_wr_en) cfg_total = cfg_wr_data;
            if (s_valid && s_ready) begin
                want = resolve_request(nps_pkg::func_t'(s_func), s_scan_index,
                                       s_peak_index, s_mz_value, s_peak_count);
                awaited = {awaited, want};
            end
            if (m_valid && m_ready) begin
                if (awaited.size() == 0) begin
                    $error("result transaction with nothing awaited: scan %0d peak %0d status %0d",
                           m_new_scan, m_new_peak, m_status);
                    errs++;
                end else begin
                    want = awaited.pop_front();
                    if (m_new_scan !== want.scan) begin
                        $error("new_scan: expected %0d, got %0d", want.scan, m_new_scan);
                        errs++;
                    end
                    if (m_new_peak !== want.peak) begin
                        $error("new_peak: expected %0d, got %0d", want.peak, m_new_peak);
                        errs++;
                    end
                    if (m_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, m_status);
                        errs++;
                    end
                end
            end
        end
        mismatch_count <= mismatch_count + errs;
        awaited_count  <= awaited.size();
    end

endmodule

// ===== dv/tb_top.sv =====
// tb_top: stimulus and verdict for nearest_peak_adjacent_scan.
// Depends on nps_pkg, the block under test and nps_result_check.
`timescale 1ns / 1ps

module tb_top;

    // fill patterns for a scan
    localparam int FILL_ASCENDING = 0;
    localparam int FILL_FLAT      = 1;
    localparam int FILL_SCRAMBLED = 2;

    logic                         aclk = 1'b0;
    logic                         aresetn;
    logic                         cfg_wr_en;
    logic [nps_pkg::CFG_W-1:0]    cfg_wr_data;
    logic                         s_valid;
    logic                         s_ready;
    nps_pkg::func_t               s_func;
    logic [nps_pkg::SCAN_W-1:0]   s_scan_index;
    logic [nps_pkg::PEAK_W-1:0]   s_peak_index;
    logic [nps_pkg::MZ_W-1:0]     s_mz_value;
    logic [nps_pkg::CNT_W-1:0]    s_peak_count;
    logic                         m_valid;
    logic                         m_ready;
    logic [nps_pkg::SCAN_W-1:0]   m_new_scan;
    logic [nps_pkg::PEAK_W-1:0]   m_new_peak;
    logic [nps_pkg::STATUS_W-1:0] m_status;
    int                           awaited_count;
    int                           mismatch_count;

    // Stimulus-side bookkeeping: which peak slots hold data and how long each
    // scan is, so no step ever reads a slot that was never written.
    bit          wr_seen [nps_pkg::MAX_SCANS*nps_pkg::MAX_PEAKS];
    int unsigned scan_len [nps_pkg::MAX_SCANS];
    int          cfg_total     = 64;
    int          src_idle_pct  = 0;
    int          snk_stall_pct = 0;
    int          sent_count    = 0;
    int          hot_scan      = 0;
    logic [nps_pkg::MZ_W-1:0] win_lo = '0;

    // per phase: scan_total (last one randomized) and idling mix
    int phase_totals [6] = '{64, 1, 0, 127, 2, 64};
    int phase_src    [4] = '{0, 50, 0, 7};
    int phase_snk    [4] = '{0, 0, 50, 7};

    nearest_peak_adjacent_scan u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_func       (s_func),
        .s_scan_index (s_scan_index),
        .s_peak_index (s_peak_index),
        .s_mz_value   (s_mz_value),
        .s_peak_count (s_peak_count),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_new_scan   (m_new_scan),
        .m_new_peak   (m_new_peak),
        .m_status     (m_status)
    );

    nps_result_check u_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_func         (s_func),
        .s_scan_index   (s_scan_index),
        .s_peak_index   (s_peak_index),
        .s_mz_value     (s_mz_value),
        .s_peak_count   (s_peak_count),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_new_scan     (m_new_scan),
        .m_new_peak     (m_new_peak),
        .m_status       (m_status),
        .awaited_count  (awaited_count),
        .mismatch_count (mismatch_count)
    );

    // 12 ns clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Receiver back-pressure, redrawn every cycle.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= snk_stall_pct);
    end

    // Hard stop if the block hangs.
    initial begin
        #(64'd10_000_000);
        $display("== FAIL ==");
        $finish;
    end

    function automatic int live_scans();
        return (cfg_total > nps_pkg::MAX_SCANS) ? nps_pkg::MAX_SCANS : cfg_total;
    endfunction

    // A step is safe when its current slot is written and, should it reach
    // the search, every slot below the adjacent scan's length is written.
    function automatic bit step_is_safe(input nps_pkg::func_t f, input int sc,
                                        input int pk);
        int lim, adj;
        lim = live_scans();
        if (!wr_seen[sc * nps_pkg::MAX_PEAKS + pk]) return 1'b0;
        if (sc >= lim || pk >= scan_len[sc]) return 1'b1;
        if (f == nps_pkg::FUNC_STEP_NEXT ? (sc + 1 == lim) : (sc == 0)) return 1'b1;
        adj = (f == nps_pkg::FUNC_STEP_NEXT) ? sc + 1 : sc - 1;
        for (int i = 0; i < scan_len[adj]; i++)
            if (!wr_seen[adj * nps_pkg::MAX_PEAKS + i]) return 1'b0;
        return 1'b1;
    endfunction

    function automatic int pick_fill_mode();
        int roll;
        roll = $urandom_range(99);
        if (roll < 80) return FILL_ASCENDING;
        if (roll < 90) return FILL_FLAT;
        return FILL_SCRAMBLED;
    endfunction

    // One input transaction. Valid only drops when the sender decides to idle,
    // so back-to-back transactions keep it high across the accept edge.
    task automatic send_txn(input nps_pkg::func_t f, input int sc, input int pk,
                            input logic [nps_pkg::MZ_W-1:0] mz, input int cnt);
        if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < src_idle_pct);
        end
        s_valid      <= 1'b1;
        s_func       <= f;
        s_scan_index <= nps_pkg::SCAN_W'(sc);
        s_peak_index <= nps_pkg::PEAK_W'(pk);
        s_mz_value   <= mz;
        s_peak_count <= nps_pkg::CNT_W'(cnt);
        do @(posedge aclk); while (!s_ready);
        case (f)
            nps_pkg::FUNC_WR_PEAK: wr_seen[sc * nps_pkg::MAX_PEAKS + pk] = 1'b1;
            nps_pkg::FUNC_SET_LEN: scan_len[sc] = (cnt > nps_pkg::MAX_PEAKS)
                                                ? nps_pkg::MAX_PEAKS : cnt;
            default: ;
        endcase
        sent_count++;
    endtask

    // unused fields of each transaction carry random bits
    task automatic write_peak(input int sc, input int pk,
                              input logic [nps_pkg::MZ_W-1:0] mz);
        send_txn(nps_pkg::FUNC_WR_PEAK, sc, pk, mz, $urandom_range(511));
    endtask

    task automatic set_len(input int sc, input int cnt);
        send_txn(nps_pkg::FUNC_SET_LEN, sc, $urandom_range(255), $urandom, cnt);
    endtask

    task automatic step_from(input nps_pkg::func_t f, input int sc, input int pk);
        send_txn(f, sc, pk, $urandom, $urandom_range(511));
    endtask

    // Writes peaks 0..n-1 of a scan from the current window, then its length.
    // A full scan gets a count from 256 up so saturation is exercised.
    task automatic fill_scan(input int sc, input int n, input int mode, input int spread);
        logic [nps_pkg::MZ_W-1:0] v;
        v = win_lo + $urandom_range(0, 60);
        for (int i = 0; i < n; i++) begin
            case (mode)
                FILL_ASCENDING: v = v + $urandom_range(0, spread);
                FILL_FLAT:      v = v + (($urandom_range(3) == 0) ? 1 : 0);
                default:        v = win_lo + $urandom_range(0, 600);
            endcase
            write_peak(sc, i, v);
        end
        set_len(sc, (n == nps_pkg::MAX_PEAKS) ? $urandom_range(nps_pkg::MAX_PEAKS, 511) : n);
        hot_scan = sc;
    endtask

    // Random step, mostly in range and often near the last filled scan; falls back
    // to filling a scan when nothing safe turns up.
    task automatic random_step();
        int             lim, sc, pk;
        nps_pkg::func_t f;
        bit             found;
        lim   = live_scans();
        found = 1'b0;
        sc    = 0;
        pk    = 0;
        f     = nps_pkg::FUNC_STEP_NEXT;
        for (int tries = 0; tries < 24 && !found; tries++) begin
            f = $urandom_range(1) ? nps_pkg::FUNC_STEP_NEXT : nps_pkg::FUNC_STEP_PREV;
            if (lim == 0 || $urandom_range(99) < 12) begin
                sc = $urandom_range(63);
            end else if ($urandom_range(99) < 35) begin
                sc = hot_scan + int'($urandom_range(2)) - 1;
                if (sc < 0) sc = 0;
                if (sc > lim - 1) sc = lim - 1;
            end else begin
                sc = $urandom_range(lim - 1);
            end
            if (scan_len[sc] != 0 && $urandom_range(99) < 88)
                pk = $urandom_range(scan_len[sc] - 1);
            else
                pk = $urandom_range(255);
            found = step_is_safe(f, sc, pk);
        end
        if (found)
            step_from(f, sc, pk);
        else
            fill_scan((lim > 0) ? $urandom_range(lim - 1) : 0, $urandom_range(1, 8),
                      FILL_ASCENDING, $urandom_range(1, 200));
    endtask

    // Hold off the sender until every result is back.
    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (awaited_count != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_scan_total(input int v);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= nps_pkg::CFG_W'(v);
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        cfg_total   = v;
    endtask

    initial begin
        int lim, n_build, first, budget_end, roll;
        aresetn      <= 1'b0;
        cfg_wr_en    <= 1'b0;
        cfg_wr_data  <= '0;
        s_valid      <= 1'b0;
        s_func       <= nps_pkg::FUNC_WR_PEAK;
        s_scan_index <= '0;
        s_peak_index <= '0;
        s_mz_value   <= '0;
        s_peak_count <= '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        set_scan_total(64);

        // ---- directed part ----
        // scan 0 spans the whole m/z range
        write_peak(0, 0, 32'h0000_0000);
        write_peak(0, 1, 32'd150);
        write_peak(0, 2, 32'hFFFF_FFFF);
        set_len(0, 3);
        // scan 1: two peaks, plus a written slot just past its length
        write_peak(1, 1, 32'd200);
        write_peak(1, 0, 32'd100);
        write_peak(1, 2, 32'd300);
        set_len(1, 2);
        // last scan: only the top slot written, length saturates from 511
        write_peak(63, 255, 32'hFFFF_FFFF);
        set_len(63, 511);
        // scan 5 keeps length 0 but has slot 0 written
        write_peak(5, 0, 32'h1234_5678);

        step_from(nps_pkg::FUNC_STEP_NEXT, 0, 1);    // 150 midway in 100/200: tie goes left
        step_from(nps_pkg::FUNC_STEP_NEXT, 0, 0);    // first peak already reaches m/z 0
        step_from(nps_pkg::FUNC_STEP_NEXT, 0, 2);    // nothing reaches the top value
        step_from(nps_pkg::FUNC_STEP_PREV, 1, 0);    // bound strictly closer than neighbor
        step_from(nps_pkg::FUNC_STEP_NEXT, 1, 1);    // adjacent scan empty
        step_from(nps_pkg::FUNC_STEP_PREV, 0, 0);    // previous from scan 0: edge
        step_from(nps_pkg::FUNC_STEP_NEXT, 1, 2);    // peak index at the scan length: range
        step_from(nps_pkg::FUNC_STEP_NEXT, 63, 255); // next from the last scan: edge
        step_from(nps_pkg::FUNC_STEP_NEXT, 5, 0);    // empty current scan: range

        // ---- random part, one phase per scan_total setting ----
        phase_totals[5] = $urandom_range(3, 126);
        for (int ph = 0; ph < 6; ph++) begin
            set_scan_total(phase_totals[ph]);
            src_idle_pct  = phase_src[ph % 4];
            snk_stall_pct = phase_snk[ph % 4];
            if (ph == 1)
                win_lo = '0;
            else if (ph == 3)
                win_lo = 32'hFFFF_0000;
            else
                win_lo = $urandom_range(0, 32'hFFFF_0000);

            // populate a run of neighboring scans plus both ends of the map
            lim     = live_scans();
            n_build = (lim < 8) ? lim : 8;
            first   = (lim > 8) ? $urandom_range(lim - 8) : 0;
            for (int k = 0; k < n_build; k++)
                fill_scan(first + k, $urandom_range(0, 8), pick_fill_mode(),
                          $urandom_range(1, 200));
            if (lim > 8) begin
                fill_scan(lim - 1, $urandom_range(1, 8), FILL_ASCENDING, 100);
                fill_scan(0, $urandom_range(1, 8), FILL_ASCENDING, 100);
            end
            if (lim == 0) begin
                fill_scan(0, 4, FILL_ASCENDING, 50);
                fill_scan(1, 4, FILL_ASCENDING, 50);
            end

            // one full-size scan with spread-out neighbors for the deepest searches
            if (ph == 0) begin
                fill_scan(19, $urandom_range(4, 12), FILL_ASCENDING, 900);
                fill_scan(21, $urandom_range(4, 12), FILL_ASCENDING, 900);
                fill_scan(20, nps_pkg::MAX_PEAKS, FILL_ASCENDING, 40);
            end

            budget_end = sent_count + 75;
            while (sent_count < budget_end) begin
                lim  = live_scans();
                roll = $urandom_range(99);
                if (roll < 12) begin
                    fill_scan((lim > 0 && $urandom_range(99) < 80) ? $urandom_range(lim - 1)
                                                                   : $urandom_range(63),
                              $urandom_range(0, 10), pick_fill_mode(),
                              $urandom_range(1, 200));
                end else if (roll < 18) begin
                    // noise: stray writes and arbitrary lengths
                    if ($urandom_range(1))
                        write_peak($urandom_range(63), $urandom_range(255), $urandom);
                    else
                        set_len($urandom_range(63), $urandom_range(511));
                end else begin
                    random_step();
                end
            end
        end

        drain_results();
        repeat (40) @(posedge aclk);
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
